// ----- hw/rtl/yags_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YAGS predictor package
// Transaction types, unit status and state encodings shared by the predictor.
// ----------------------------------------------------------------------------

package yags_pkg;

   localparam int PC_BITS     = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [PC_BITS-1:0] pc;
      logic               taken;
   } req_type;

   typedef struct packed {
      logic predicted_taken;
      logic correct;
   } rsp_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MOD,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_MOD,
      B_READ,
      B_EXEC
   } back_state_type;

endpackage

// ----- hw/rtl/yags_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YAGS index reduction
// Remainder of a 32-bit operand by a constant modulus, by reciprocal
// multiplication, with the quotient, its product and the remainder registered in turn.
// ----------------------------------------------------------------------------

module yags_mod #(
   parameter int MODULUS = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [yags_pkg::PC_BITS-1:0] operand,
   output logic                       done,
   output logic [$clog2(MODULUS)-1:0] remainder
);

   localparam int XW    = yags_pkg::PC_BITS;
   localparam int RW    = $clog2(MODULUS);
   localparam int SHIFT = XW - 1 + RW;
   localparam int QW    = 2 * XW - SHIFT;
   localparam logic [XW-1:0] RECIP = XW'((64'd1 << SHIFT) / 64'(MODULUS));
   localparam logic [XW-1:0] MOD_D = XW'(MODULUS);

   logic [XW-1:0]   opnd_ff, opnd_in;
   logic [QW-1:0]   quot_ff, quot_in;
   logic [XW-1:0]   qd_ff, qd_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [3:0]      stage_ff, stage_in;
   logic [2*XW-1:0] product;

   // quotient estimate is exact or one low
   assign product = (2*XW)'(opnd_ff) * (2*XW)'(RECIP);

   always_comb begin
      logic [XW-1:0] diff;
      opnd_in  = start ? operand : opnd_ff;
      quot_in  = product[2*XW-1:SHIFT];
      qd_in    = XW'(quot_ff) * MOD_D;
      diff     = opnd_ff - qd_ff;
      if (diff >= MOD_D) begin
         diff = diff - MOD_D;
      end
      rem_in   = diff[RW-1:0];
      stage_in = {stage_ff[2:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      quot_ff <= quot_in;
      qd_ff   <= qd_in;
      rem_ff  <= rem_in;
   end

   assign done      = stage_ff[3];
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/yags_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YAGS branch queue
// Small in-order queue between the accept stage and the table update stage.
// ----------------------------------------------------------------------------

module yags_fifo #(
   parameter int WIDTH = 44,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [NW-1:0] CNT_FULL = NW'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/yags_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YAGS accept stage
// Takes a resolved branch, reduces its choice index and queues the transaction.
// ----------------------------------------------------------------------------

module yags_front #(
   parameter int CHOICE_ENTRIES = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  yags_pkg::req_type                 req_item,
   input  logic                              hold,
   output logic                              busy,
   output logic                              push,
   output logic [yags_pkg::PC_BITS+$clog2(CHOICE_ENTRIES):0] push_data,
   input  logic                              queue_full
);

   localparam int CW = $clog2(CHOICE_ENTRIES);

   yags_pkg::front_state_type state_ff, state_in;
   yags_pkg::req_type         item_ff, item_in;
   logic [CW-1:0]             ci_ff, ci_in;
   logic                      accept;
   logic                      mod_done;
   logic [CW-1:0]             mod_rem;

   assign busy   = (state_ff != yags_pkg::F_IDLE) || hold;
   assign accept = start && !busy;

   yags_mod #(
      .MODULUS (CHOICE_ENTRIES)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .operand   (req_item.pc),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      ci_in    = ci_ff;
      push     = 1'b0;
      unique case (state_ff)
         yags_pkg::F_IDLE: begin
            if (accept) begin
               item_in  = req_item;
               state_in = yags_pkg::F_MOD;
            end
         end
         yags_pkg::F_MOD: begin
            if (mod_done) begin
               ci_in    = mod_rem;
               state_in = yags_pkg::F_PUSH;
            end
         end
         yags_pkg::F_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = yags_pkg::F_IDLE;
            end
         end
         default: state_in = yags_pkg::F_IDLE;
      endcase
   end

   assign push_data = {item_ff.pc, item_ff.taken, ci_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= yags_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      ci_ff   <= ci_in;
   end

endmodule

// ----- hw/rtl/yags_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YAGS table update stage
// Reads the choice and bias caches, predicts, reports and updates the tables.
// ----------------------------------------------------------------------------

module yags_back #(
   parameter int CHOICE_ENTRIES = 2048,
   parameter int CACHE_ENTRIES  = 512,
   parameter int TAG_BITS       = 8,
   parameter int COUNTER_BITS   = 2,
   parameter int HIST_BITS      = 9
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              queue_empty,
   input  logic [yags_pkg::PC_BITS+$clog2(CHOICE_ENTRIES):0] pop_data,
   output logic                              pop,
   output yags_pkg::back_status_type         status,
   output logic                              rsp_valid,
   output yags_pkg::rsp_type                 rsp_item
);

   localparam int CW    = $clog2(CHOICE_ENTRIES);
   localparam int KW    = $clog2(CACHE_ENTRIES);
   localparam int CB    = COUNTER_BITS;
   localparam int CLR_W = (CW > KW) ? CW : KW;
   localparam int CLEAR_LEN = (CHOICE_ENTRIES > CACHE_ENTRIES) ? CHOICE_ENTRIES
                                                               : CACHE_ENTRIES;
   localparam logic [CLR_W-1:0] CLEAR_LAST = CLR_W'(CLEAR_LEN - 1);
   localparam logic [CLR_W:0]   CHOICE_LIM = (CLR_W+1)'(CHOICE_ENTRIES);
   localparam logic [CLR_W:0]   CACHE_LIM  = (CLR_W+1)'(CACHE_ENTRIES);
   localparam logic [CB-1:0]    CTR_MAX    = '1;

   function automatic logic [CB-1:0] nudge(input logic [CB-1:0] ctr, input logic up);
      logic [CB-1:0] res;
      res = ctr;
      if (up) begin
         if (ctr != CTR_MAX) res = ctr + 1'b1;
      end else if (ctr != '0) begin
         res = ctr - 1'b1;
      end
      return res;
   endfunction

   logic [CB-1:0]       choice_mem [CHOICE_ENTRIES];
   logic [CB-1:0]       tk_ctr_mem [CACHE_ENTRIES];
   logic [TAG_BITS-1:0] tk_tag_mem [CACHE_ENTRIES];
   logic [CB-1:0]       nt_ctr_mem [CACHE_ENTRIES];
   logic [TAG_BITS-1:0] nt_tag_mem [CACHE_ENTRIES];

   yags_pkg::back_state_type     state_ff, state_in;
   logic [CLR_W-1:0]             clear_ff, clear_in;
   logic [HIST_BITS-1:0]         hist_ff, hist_in;
   logic [TAG_BITS-1:0]          tag_ff, tag_in;
   logic                         taken_ff, taken_in;
   logic [CW-1:0]                ci_ff, ci_in;
   logic [KW-1:0]                ki_ff, ki_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   yags_pkg::rsp_type            rsp_ff, rsp_in;

   logic [CB-1:0]       choice_rd_ff;
   logic [CB-1:0]       tk_ctr_rd_ff, nt_ctr_rd_ff;
   logic [TAG_BITS-1:0] tk_tag_rd_ff, nt_tag_rd_ff;

   logic                         choice_we;
   logic [CW-1:0]                choice_waddr;
   logic [CB-1:0]                choice_wdata;
   logic                         tk_we, nt_we;
   logic [KW-1:0]                cache_waddr;
   logic [CB-1:0]                tk_ctr_wdata, nt_ctr_wdata;
   logic [TAG_BITS-1:0]          tk_tag_wdata, nt_tag_wdata;

   logic                         mod_start;
   logic [yags_pkg::PC_BITS-1:0] mod_operand;
   logic                         mod_done;
   logic [KW-1:0]                mod_rem;

   logic [yags_pkg::PC_BITS-1:0] pop_pc;
   logic                         pop_taken;
   logic [CW-1:0]                pop_ci;

   logic                choice_bit;
   logic [CB-1:0]       cache_ctr;
   logic [TAG_BITS-1:0] cache_tag;
   logic [TAG_BITS-1:0] item_tag;
   logic                hit, pred, correct;
   logic                cache_upd, choice_upd;
   logic [CB-1:0]       cache_ctr_next;

   assign {pop_pc, pop_taken, pop_ci} = pop_data;

   assign mod_operand = pop_pc ^ {{(yags_pkg::PC_BITS-HIST_BITS){1'b0}}, hist_ff};

   yags_mod #(
      .MODULUS (CACHE_ENTRIES)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .operand   (mod_operand),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign choice_bit     = choice_rd_ff[CB-1];
   assign cache_ctr      = choice_bit ? nt_ctr_rd_ff : tk_ctr_rd_ff;
   assign cache_tag      = choice_bit ? nt_tag_rd_ff : tk_tag_rd_ff;
   assign item_tag       = tag_ff;
   assign hit            = (cache_tag == item_tag);
   assign pred           = hit ? cache_ctr[CB-1] : choice_bit;
   assign correct        = (pred == taken_ff);
   assign cache_upd      = hit || !correct;
   assign choice_upd     = !((choice_bit != taken_ff) && correct);
   assign cache_ctr_next = nudge(cache_ctr, taken_ff);

   always_comb begin
      state_in     = state_ff;
      clear_in     = clear_ff;
      hist_in      = hist_ff;
      tag_in       = tag_ff;
      taken_in     = taken_ff;
      ci_in        = ci_ff;
      ki_in        = ki_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      mod_start    = 1'b0;
      choice_we    = 1'b0;
      choice_waddr = ci_ff;
      choice_wdata = nudge(choice_rd_ff, taken_ff);
      tk_we        = 1'b0;
      nt_we        = 1'b0;
      cache_waddr  = ki_ff;
      tk_ctr_wdata = cache_ctr_next;
      nt_ctr_wdata = cache_ctr_next;
      tk_tag_wdata = item_tag;
      nt_tag_wdata = item_tag;
      unique case (state_ff)
         yags_pkg::B_CLEAR: begin
            choice_waddr = clear_ff[CW-1:0];
            cache_waddr  = clear_ff[KW-1:0];
            choice_wdata = '0;
            tk_ctr_wdata = CTR_MAX;
            nt_ctr_wdata = '0;
            tk_tag_wdata = '0;
            nt_tag_wdata = '0;
            choice_we    = ({1'b0, clear_ff} < CHOICE_LIM);
            tk_we        = ({1'b0, clear_ff} < CACHE_LIM);
            nt_we        = tk_we;
            clear_in     = clear_ff + 1'b1;
            if (clear_ff == CLEAR_LAST) begin
               state_in = yags_pkg::B_IDLE;
            end
         end
         yags_pkg::B_IDLE: begin
            if (!queue_empty) begin
               pop       = 1'b1;
               mod_start = 1'b1;
               tag_in    = pop_pc[TAG_BITS-1:0];
               taken_in  = pop_taken;
               ci_in     = pop_ci;
               state_in  = yags_pkg::B_MOD;
            end
         end
         yags_pkg::B_MOD: begin
            if (mod_done) begin
               ki_in    = mod_rem;
               state_in = yags_pkg::B_READ;
            end
         end
         yags_pkg::B_READ: begin
            state_in = yags_pkg::B_EXEC;
         end
         yags_pkg::B_EXEC: begin
            choice_we              = choice_upd;
            tk_we                  = cache_upd && !choice_bit;
            nt_we                  = cache_upd && choice_bit;
            hist_in                = {hist_ff[HIST_BITS-1:0] << 1} | HIST_BITS'(taken_ff);
            rsp_valid_in           = 1'b1;
            rsp_in.predicted_taken = pred;
            rsp_in.correct         = correct;
            state_in               = yags_pkg::B_IDLE;
         end
         default: state_in = yags_pkg::B_IDLE;
      endcase
   end

   assign status.clearing = (state_ff == yags_pkg::B_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= yags_pkg::B_CLEAR;
         clear_ff     <= '0;
         hist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      taken_ff <= taken_in;
      ci_ff    <= ci_in;
      ki_ff    <= ki_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (choice_we) begin
         choice_mem[choice_waddr] <= choice_wdata;
      end
      choice_rd_ff <= choice_mem[ci_ff];
   end

   always_ff @(posedge clock) begin
      if (tk_we) begin
         tk_ctr_mem[cache_waddr] <= tk_ctr_wdata;
         tk_tag_mem[cache_waddr] <= tk_tag_wdata;
      end
      tk_ctr_rd_ff <= tk_ctr_mem[ki_ff];
      tk_tag_rd_ff <= tk_tag_mem[ki_ff];
   end

   always_ff @(posedge clock) begin
      if (nt_we) begin
         nt_ctr_mem[cache_waddr] <= nt_ctr_wdata;
         nt_tag_mem[cache_waddr] <= nt_tag_wdata;
      end
      nt_ctr_rd_ff <= nt_ctr_mem[ki_ff];
      nt_tag_rd_ff <= nt_tag_mem[ki_ff];
   end

endmodule

// ----- hw/rtl/yags_branch_predictor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YAGS branch predictor unit
// Resolved-branch predictor with a choice table and two opposite-bias caches.
// ----------------------------------------------------------------------------
//
//  channel   ports                       handshake
//  -------   -------------------------   ---------------------------------
//  request   start, busy, req_item       taken when start && !busy
//  response  rsp_valid, rsp_item         one-cycle strobe, cannot be held
//
//  Both table indices come from reciprocal-multiply remainder units. The
//  accept stage holds busy until its transaction is pushed into the queue,
//  so it can take a new branch while the update stage still works on an
//  earlier one. The update stage passes each transaction through index
//  reduction, a registered table read and write-back. After reset, busy
//  stays high while the tables are cleared.

module yags_branch_predictor_unit #(
   parameter int CHOICE_ENTRIES = 2048,
   parameter int CACHE_ENTRIES  = 512,
   parameter int TAG_BITS       = 8,
   parameter int COUNTER_BITS   = 2,
   parameter int HIST_BITS      = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  yags_pkg::req_type req_item,
   output logic              rsp_valid,
   output yags_pkg::rsp_type rsp_item
);

   localparam int QW = yags_pkg::PC_BITS + $clog2(CHOICE_ENTRIES) + 1;

   logic                      push, pop;
   logic [QW-1:0]             push_data, pop_data;
   logic                      queue_full, queue_empty;
   yags_pkg::back_status_type back_status;

   yags_front #(
      .CHOICE_ENTRIES (CHOICE_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .hold       (back_status.clearing),
      .busy       (busy),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   yags_fifo #(
      .WIDTH (QW),
      .DEPTH (yags_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   yags_back #(
      .CHOICE_ENTRIES (CHOICE_ENTRIES),
      .CACHE_ENTRIES  (CACHE_ENTRIES),
      .TAG_BITS       (TAG_BITS),
      .COUNTER_BITS   (COUNTER_BITS),
      .HIST_BITS      (HIST_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .status      (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YAGS branch predictor unit testbench
// Drives resolved branches, directed and then in random bursts, through the
// start/busy handshake, mirrors the choice table, both opposite-bias caches
// and global history to predict and check every rsp_valid strobe in order.
// ----------------------------------------------------------------------------

class yags_mirror;
   localparam int CHOICE_N = 2048;
   localparam int CACHE_N  = 512;
   localparam int TAG_W    = 8;
   localparam int CTR_W    = 2;
   localparam int HIST_W   = 9;

   bit [CTR_W-1:0]    choice_ctr[CHOICE_N];
   bit [CTR_W-1:0]    taken_ctr[CACHE_N];
   bit [TAG_W-1:0]    taken_tag[CACHE_N];
   bit [CTR_W-1:0]    not_taken_ctr[CACHE_N];
   bit [TAG_W-1:0]    not_taken_tag[CACHE_N];
   bit [HIST_W-1:0]   hist;
   yags_pkg::rsp_type predictions_due[$];
   yags_pkg::req_type branches_due[$];
   int                errors;

   function new();
      foreach (choice_ctr[i]) choice_ctr[i] = '0;
      foreach (taken_ctr[i]) begin
         taken_ctr[i]     = '1;
         taken_tag[i]     = '0;
         not_taken_ctr[i] = '0;
         not_taken_tag[i] = '0;
      end
      hist   = '0;
      errors = 0;
   endfunction

   function bit [CTR_W-1:0] saturate_toward(bit [CTR_W-1:0] ctr, bit up);
      if (up) return (ctr == '1) ? ctr : ctr + 1'b1;
      return (ctr == '0) ? ctr : ctr - 1'b1;
   endfunction

   function void record_branch(yags_pkg::req_type br);
      int unsigned       ci;
      int unsigned       ki;
      bit                bias;
      bit                hit;
      bit                guess;
      bit                ok;
      bit [TAG_W-1:0]    tag;
      yags_pkg::rsp_type exp_rsp;
      ci   = br.pc % CHOICE_N;
      ki   = (br.pc ^ 32'(hist)) % CACHE_N;
      tag  = br.pc[TAG_W-1:0];
      bias = choice_ctr[ci][CTR_W-1];
      if (bias) begin
         hit   = (not_taken_tag[ki] == tag);
         guess = hit ? not_taken_ctr[ki][CTR_W-1] : bias;
      end else begin
         hit   = (taken_tag[ki] == tag);
         guess = hit ? taken_ctr[ki][CTR_W-1] : bias;
      end
      ok = (guess == br.taken);
      if (hit || !ok) begin
         if (bias) begin
            not_taken_ctr[ki] = saturate_toward(not_taken_ctr[ki], br.taken);
            not_taken_tag[ki] = tag;
         end else begin
            taken_ctr[ki] = saturate_toward(taken_ctr[ki], br.taken);
            taken_tag[ki] = tag;
         end
      end
      if (!((bias != br.taken) && ok))
         choice_ctr[ci] = saturate_toward(choice_ctr[ci], br.taken);
      hist = {hist[HIST_W-2:0], br.taken};
      exp_rsp.predicted_taken = guess;
      exp_rsp.correct         = ok;
      predictions_due.push_back(exp_rsp);
      branches_due.push_back(br);
   endfunction

   function void check_prediction(yags_pkg::rsp_type got);
      yags_pkg::rsp_type exp_rsp;
      yags_pkg::req_type br;
      if (predictions_due.size() == 0) begin
         $display("%0t: unexpected response predicted_taken=%0b correct=%0b",
                  $time, got.predicted_taken, got.correct);
         errors++;
         return;
      end
      exp_rsp = predictions_due.pop_front();
      br      = branches_due.pop_front();
      if (got.predicted_taken !== exp_rsp.predicted_taken) begin
         $display("%0t: pc=%h taken=%0b predicted_taken expected %0b got %0b",
                  $time, br.pc, br.taken, exp_rsp.predicted_taken, got.predicted_taken);
         errors++;
      end
      if (got.correct !== exp_rsp.correct) begin
         $display("%0t: pc=%h taken=%0b correct expected %0b got %0b",
                  $time, br.pc, br.taken, exp_rsp.correct, got.correct);
         errors++;
      end
   endfunction

   function int pending();
      return predictions_due.size();
   endfunction
endclass

module testbench;

   localparam int RANDOM_BRANCHES = 1200;
   localparam int POOL_SIZE       = 24;
   localparam int DRAIN_LIMIT     = 20000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   yags_pkg::req_type req_item;
   logic              rsp_valid;
   yags_pkg::rsp_type rsp_item;

   yags_mirror  mirror;
   logic [31:0] pc_pool[POOL_SIZE];
   bit          pool_bias[POOL_SIZE];
   int          burst_left;

   yags_branch_predictor_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) mirror.record_branch(req_item);
         if (rsp_valid) mirror.check_prediction(rsp_item);
      end
   end

   // hold start high until the transaction is taken
   task automatic send_branch(logic [31:0] pc, logic taken);
      yags_pkg::req_type br;
      br.pc    = pc;
      br.taken = taken;
      start    <= 1'b1;
      req_item <= br;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (mirror.pending() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (mirror.pending() != 0) begin
         $display("%0t: %0d responses never arrived", $time, mirror.pending());
         mirror.errors++;
      end
   endtask

   // bursts of random length, random gaps, occasional long runs with no gap
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 30));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 15);
   endtask

   task automatic random_branch();
      int          k;
      logic [31:0] pc;
      logic        taken;
      case ($urandom_range(0, 9))
         0, 1: begin
            pc    = $urandom;
            taken = $urandom_range(0, 1);
         end
         2: begin
            // low tag byte cleared: matches never-written cache tags
            pc    = $urandom & 32'hFFFF_FF00;
            taken = $urandom_range(0, 1);
         end
         default: begin
            k     = $urandom_range(0, POOL_SIZE - 1);
            pc    = pc_pool[k];
            taken = ($urandom_range(0, 99) < 85) ? pool_bias[k] : ~pool_bias[k];
         end
      endcase
      send_branch(pc, taken);
   endtask

   initial begin
      mirror     = new();
      burst_left = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pc_pool[i]   = $urandom;
         pool_bias[i] = $urandom_range(0, 1);
      end
      // alias choice entries and cache tags across pool members
      pc_pool[1] = {pc_pool[0][31:11] ^ 21'h1, pc_pool[0][10:0]};
      pc_pool[3] = {pc_pool[2][31:8] ^ 24'h2, pc_pool[2][7:0]};
      pc_pool[5] = pc_pool[4] & 32'hFFFF_FF00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'h0000_0000, 1'b0);
      send_branch(32'hFFFF_FFFF, 1'b1);
      send_branch(32'hFFFF_FFFF, 1'b0);
      repeat (4) send_branch(32'h0000_0100, 1'b1);
      repeat (3) send_branch(32'h0000_0100, 1'b0);
      send_branch(32'h8000_0000, 1'b0);
      send_branch(32'h8000_0000, 1'b1);
      send_branch(32'hAAAA_AAAA, 1'b1);
      send_branch(32'h5555_5555, 1'b0);
      send_branch(32'h0000_07FF, 1'b1);
      send_branch(32'h0000_0800, 1'b1);
      send_branch(32'h0000_0800, 1'b0);
      idle_cycles(5);
      send_branch(32'h1234_5600, 1'b0);
      send_branch(32'h7FFF_FFFF, 1'b1);
      send_branch(32'hFFFF_F800, 1'b1);
      wait_drained();

      for (int n = 0; n < RANDOM_BRANCHES; n++) begin
         if (n == RANDOM_BRANCHES / 2) wait_drained();
         pace_sender();
         random_branch();
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (mirror.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
